// ===== hw/rtl/round_robin_task_assigner_defines.svh =====
// Assertion macros used by the task assigner's engine.
`ifndef ROUND_ROBIN_TASK_ASSIGNER_DEFINES_SVH
`define ROUND_ROBIN_TASK_ASSIGNER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RRTA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RRTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rrta_pkg.sv =====
// Constants, codes and shared types of the round-robin task assigner.
package rrta_pkg;

  localparam int MAX_TASKS   = 16;
  localparam int TASK_W      = $clog2(MAX_TASKS);
  localparam int TASKN_W     = $clog2(MAX_TASKS + 1);
  localparam int COUNT_WIDTH = 8;
  localparam int MASK_W      = 16;
  localparam int TCOUNT_W    = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL_MASK = 1'b1;

  // Operation codes of an input beat.
  localparam logic OP_REQUEST  = 1'b0;
  localparam logic OP_SHUTDOWN = 1'b1;

  typedef struct packed {
    logic [TASKN_W-1:0] n;    // effective number of tasks in the rotation
    logic [MASK_W-1:0]  par;  // parallel mask
  } rrta_cfg_t;

  typedef struct packed {
    logic              granted;
    logic [TASK_W-1:0] granted_task;
    logic              deactivated;
    logic [TASK_W-1:0] deactivated_task;
  } rrta_result_t;

endpackage

// ===== hw/rtl/rrta_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rrta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/rrta_cfg.sv =====
// Configuration registers and the effective task count of the rotation.
module rrta_cfg
  import rrta_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output rrta_cfg_t             cfg
);

  logic [TCOUNT_W-1:0] task_count;
  logic [MASK_W-1:0]   parallel_mask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count    <= TCOUNT_W'(MAX_TASKS);
      parallel_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TASK_COUNT:    task_count    <= cfg_data[TCOUNT_W-1:0];
        CFG_PARALLEL_MASK: parallel_mask <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // A count of zero acts as one; counts above the storage clamp to it.
  always_comb begin
    if (task_count == '0) begin
      cfg.n = TASKN_W'(1);
    end else if (32'(task_count) > MAX_TASKS) begin
      cfg.n = TASKN_W'(MAX_TASKS);
    end else begin
      cfg.n = TASKN_W'(task_count);
    end
    cfg.par = parallel_mask;
  end

endmodule

// ===== hw/rtl/rrta_engine.sv =====
// Sequencer that returns a held task and scans the worker counts in memory.
`include "round_robin_task_assigner_defines.svh"

module rrta_engine
  import rrta_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  rrta_cfg_t         cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              operation,
  input  logic              holds_task,
  input  logic [TASK_W-1:0] returned_task,
  input  logic [MASK_W-1:0] finished_mask,
  output logic              res_valid,
  input  logic              res_ready,
  output rrta_result_t      res
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RET  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;

  logic              op_q;
  logic [TASK_W-1:0] ret_q;
  logic [MASK_W-1:0] fin_q;
  logic              gnt_q;
  logic [TASK_W-1:0] gtask_q;
  logic              deact_q;
  logic [TASK_W-1:0] dtask_q;
  logic [TASK_W-1:0] ptr;
  logic [TASKN_W-1:0] iss;
  logic [TASK_W-1:0] cur_t;
  logic              ev_pend;
  logic [TASK_W-1:0] ev_t;
  logic [MAX_TASKS-1:0] cnt_vld;
  logic              rd_vld;

  logic                   in_acc;
  logic                   re;
  logic [TASK_W-1:0]      raddr;
  logic                   we;
  logic [TASK_W-1:0]      waddr;
  logic [COUNT_WIDTH-1:0] wdata;
  logic [COUNT_WIDTH-1:0] rdata;
  logic [COUNT_WIDTH-1:0] cnt_eff;
  logic [TASK_W-1:0]      scan_start;
  logic [TASK_W-1:0]      cur_t_next;
  logic [TASK_W-1:0]      ptr_next;
  logic                   hit;
  logic                   ret_ok;

  rrta_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MAX_TASKS)
  ) u_counts (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Entries never written since reset read as zero.
  assign cnt_eff = rd_vld ? rdata : '0;

  assign ret_ok     = (32'(returned_task) < MAX_TASKS);
  assign scan_start = ({1'b0, ptr} < cfg.n) ? ptr : '0;
  assign cur_t_next = (({1'b0, cur_t} + TASKN_W'(1)) >= cfg.n) ? '0 : cur_t + 1'b1;
  assign ptr_next   = (({1'b0, ev_t} + TASKN_W'(1)) >= cfg.n) ? '0 : ev_t + 1'b1;
  assign hit = ev_pend && !fin_q[ev_t] && (cfg.par[ev_t] || (cnt_eff == '0));

  always_comb begin
    re    = 1'b0;
    raddr = returned_task;
    we    = 1'b0;
    waddr = ret_q;
    wdata = cnt_eff - 1'b1;
    case (state)
      ST_IDLE: begin
        re    = in_acc && holds_task && ret_ok;
        raddr = returned_task;
      end
      ST_RET: begin
        we    = (cnt_eff != '0);
        waddr = ret_q;
        wdata = cnt_eff - 1'b1;
      end
      ST_SCAN: begin
        re    = (iss < cfg.n);
        raddr = cur_t;
        we    = hit;
        waddr = ev_t;
        wdata = (cnt_eff == COUNT_MAX) ? cnt_eff : cnt_eff + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      ptr     <= '0;
      cnt_vld <= '0;
      ev_pend <= 1'b0;
    end else begin
      if (we) begin
        cnt_vld[waddr] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            iss     <= '0;
            cur_t   <= scan_start;
            ev_pend <= 1'b0;
            if (holds_task && ret_ok) begin
              state <= ST_RET;
            end else if (operation == OP_REQUEST) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_RET: begin
          state <= (op_q == OP_REQUEST) ? ST_SCAN : ST_DONE;
        end
        ST_SCAN: begin
          if (hit) begin
            ptr   <= ptr_next;
            state <= ST_DONE;
          end else if (!ev_pend && !re) begin
            state <= ST_DONE;
          end
          if (re) begin
            iss   <= iss + 1'b1;
            cur_t <= cur_t_next;
          end
          ev_pend <= re;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Item payload and result fields.
  always_ff @(posedge clk) begin
    if (re) begin
      rd_vld <= cnt_vld[raddr];
    end
    if (state == ST_SCAN) begin
      ev_t <= cur_t;
    end
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          op_q    <= operation;
          ret_q   <= returned_task;
          fin_q   <= finished_mask;
          gnt_q   <= 1'b0;
          gtask_q <= '0;
          deact_q <= 1'b0;
          dtask_q <= '0;
        end
      end
      ST_RET: begin
        // Only a count that drops from one to zero deactivates.
        if ((op_q == OP_REQUEST) && (cnt_eff == COUNT_WIDTH'(1)) && fin_q[ret_q]) begin
          deact_q <= 1'b1;
          dtask_q <= ret_q;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          gnt_q   <= 1'b1;
          gtask_q <= ev_t;
        end
      end
      default: ;
    endcase
  end

  assign res_valid            = (state == ST_DONE);
  assign res.granted          = gnt_q;
  assign res.granted_task     = gtask_q;
  assign res.deactivated      = deact_q;
  assign res.deactivated_task = dtask_q;

  `RRTA_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state != ST_IDLE, "accepted beat left engine idle")
  `RRTA_ASSERT_NOW(a_grant_not_finished, res_valid && res.granted, !fin_q[res.granted_task], "granted a finished task")
  `RRTA_ASSERT_NOW(a_shutdown_quiet, res_valid && (op_q == OP_SHUTDOWN), !res.granted && !res.deactivated, "shutdown produced a grant or deactivation")
  `RRTA_ASSERT_NOW(a_deact_is_returned, res_valid && res.deactivated, res.deactivated_task == ret_q, "deactivated task differs from returned task")
  `RRTA_ASSERT_NOW(a_scan_bound, state == ST_SCAN, iss <= cfg.n, "scan issued more reads than tasks")

endmodule

// ===== hw/rtl/round_robin_task_assigner.sv =====
// An accepted beat moves through the engine states ST_RET, ST_SCAN and ST_DONE as needed, then into
// the output register that drives out_valid. The scan reads one worker count per cycle from the count
// memory, one read port; a returned task first passes ST_RET for its decrement, and a scan that finds no
// task drains its last read. Items are handled one at a time; the next beat is taken once the result
// enters the output register.
// Reset clears the worker counts (per-entry valid bits), the resume pointer, the engine state and
// out_valid, and sets task_count to 16 and parallel_mask to zero; no clearing pass is needed.
module round_robin_task_assigner
  import rrta_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  operation,
  input  logic                  holds_task,
  input  logic [TASK_W-1:0]     returned_task,
  input  logic [MASK_W-1:0]     finished_mask,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  granted,
  output logic [TASK_W-1:0]     granted_task,
  output logic                  deactivated,
  output logic [TASK_W-1:0]     deactivated_task,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  rrta_cfg_t    cfg;
  rrta_result_t res;
  logic         res_valid;
  logic         res_ready;

  rrta_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rrta_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .holds_task    (holds_task),
    .returned_task (returned_task),
    .finished_mask (finished_mask),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // The output register frees the engine as soon as a result beat is loaded.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      granted          <= res.granted;
      granted_task     <= res.granted_task;
      deactivated      <= res.deactivated;
      deactivated_task <= res.deactivated_task;
    end
  end

endmodule

// ===== verif/round_robin_task_assigner_tb.sv =====
// Self-checking bench for the round-robin task assigner: directed table, then random phases.
`timescale 1ns / 100ps

module testbench;
  import rrta_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 150;
  localparam int NUM_PHASES  = 8;

  typedef struct packed {
    logic              op;
    logic              holds;
    logic [TASK_W-1:0] task_id;
    logic [MASK_W-1:0] fin;
  } assign_req_t;

  typedef struct packed {
    logic         known;
    assign_req_t  req;
    rrta_result_t res;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  operation;
  logic                  holds_task;
  logic [TASK_W-1:0]     returned_task;
  logic [MASK_W-1:0]     finished_mask;
  logic                  out_valid;
  logic                  out_stall;
  logic                  granted;
  logic [TASK_W-1:0]     granted_task;
  logic                  deactivated;
  logic [TASK_W-1:0]     deactivated_task;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow state of the block.
  logic [COUNT_WIDTH-1:0] worker_cnt [MAX_TASKS];
  int                     resume_ptr;
  logic [TCOUNT_W-1:0]    tcount_reg;
  logic [MASK_W-1:0]      par_reg;

  rrta_result_t expected_assignments [$];
  dir_row_t     dir_table [16];
  int unsigned  err_cnt;
  int unsigned  idle_cycles;
  bit           reset_done;
  bit           no_gaps;
  bit           hold_off_req;

  round_robin_task_assigner dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .holds_task       (holds_task),
    .returned_task    (returned_task),
    .finished_mask    (finished_mask),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .granted          (granted),
    .granted_task     (granted_task),
    .deactivated      (deactivated),
    .deactivated_task (deactivated_task),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Returns true when the count of the handed-back task drops from one to zero.
  function automatic bit drop_worker(input logic [TASK_W-1:0] t);
    if (worker_cnt[t] == '0) begin
      return 1'b0;
    end
    worker_cnt[t] = worker_cnt[t] - 1'b1;
    return worker_cnt[t] == '0;
  endfunction

  function automatic rrta_result_t assign_next(input assign_req_t rq);
    rrta_result_t res;
    int           n;
    int           start;
    int           t;
    bit           dropped;
    bit           found;
    res = '0;
    found = 1'b0;
    dropped = rq.holds ? drop_worker(rq.task_id) : 1'b0;
    if (rq.op == OP_REQUEST) begin
      if (dropped && rq.fin[rq.task_id]) begin
        res.deactivated = 1'b1;
        res.deactivated_task = rq.task_id;
      end
      if (tcount_reg == '0) begin
        n = 1;
      end else if (int'(tcount_reg) > MAX_TASKS) begin
        n = MAX_TASKS;
      end else begin
        n = int'(tcount_reg);
      end
      // A pointer left beyond a shrunken rotation restarts the scan at task zero.
      start = (resume_ptr < n) ? resume_ptr : 0;
      for (int i = 0; i < n; i++) begin
        t = start + i;
        if (t >= n) begin
          t = t - n;
        end
        if (!found && !rq.fin[t] && (par_reg[t] || worker_cnt[t] == '0)) begin
          found = 1'b1;
          res.granted = 1'b1;
          res.granted_task = TASK_W'(t);
          if (worker_cnt[t] != COUNT_MAX) begin
            worker_cnt[t] = worker_cnt[t] + 1'b1;
          end
          resume_ptr = (t + 1 >= n) ? 0 : t + 1;
        end
      end
    end
    return res;
  endfunction

  // Mostly hands back tasks that really have workers, so deactivations come up often.
  function automatic assign_req_t make_req(input bit saturate);
    assign_req_t rq;
    int unsigned pick;
    bit          found;
    rq.op = OP_REQUEST;
    if (!saturate && $urandom_range(0, 99) < 15) begin
      rq.op = OP_SHUTDOWN;
    end
    rq.task_id = TASK_W'($urandom_range(0, MAX_TASKS - 1));
    pick = $urandom_range(0, MAX_TASKS - 1);
    found = 1'b0;
    for (int k = 0; k < MAX_TASKS; k++) begin
      if (!found && worker_cnt[(pick + k) % MAX_TASKS] != '0) begin
        found = 1'b1;
        rq.task_id = TASK_W'((pick + k) % MAX_TASKS);
      end
    end
    if (saturate) begin
      rq.holds = ($urandom_range(0, 99) < 5);
      rq.fin = MASK_W'($urandom);
      rq.fin[0] = 1'b0;
    end else begin
      rq.holds = found ? ($urandom_range(0, 99) < 75) : ($urandom_range(0, 99) < 30);
      case ($urandom_range(0, 9))
        0: rq.fin = '0;
        1: rq.fin = '1;
        2, 3, 4: rq.fin = MASK_W'($urandom);
        default: rq.fin = MASK_W'($urandom & $urandom & $urandom);
      endcase
      if (rq.holds && $urandom_range(0, 2) == 0) begin
        rq.fin[rq.task_id] = 1'b1;
      end
    end
    return rq;
  endfunction

  function automatic dir_row_t dir_row(input logic known, input logic op, input logic holds,
                                       input logic [TASK_W-1:0] tid, input logic [MASK_W-1:0] fin,
                                       input logic g, input logic [TASK_W-1:0] gt,
                                       input logic d, input logic [TASK_W-1:0] dt);
    dir_row_t row_val;
    row_val.known = known;
    row_val.req = '{op, holds, tid, fin};
    row_val.res = '{g, gt, d, dt};
    return row_val;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  task automatic send_req(input assign_req_t rq);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= rq.op;
    holds_task <= rq.holds;
    returned_task <= rq.task_id;
    finished_mask <= rq.fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TASK_COUNT: tcount_reg = data[TCOUNT_W-1:0];
      CFG_PARALLEL_MASK: par_reg = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [TCOUNT_W-1:0] tc, input logic [MASK_W-1:0] pm);
    reg_write(CFG_TASK_COUNT, CFG_DATA_W'(tc));
    reg_write(CFG_PARALLEL_MASK, pm);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained;
    while (expected_assignments.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int                  n_items;
    bit                  sat;
    logic [TCOUNT_W-1:0] tc;
    logic [MASK_W-1:0]   pm;
    assign_req_t         rq;
    rrta_result_t        got;
    rst <= 1'b1;
    in_valid <= 1'b0;
    operation <= OP_REQUEST;
    holds_task <= 1'b0;
    returned_task <= '0;
    finished_mask <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_TASK_COUNT;
    cfg_data <= '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      worker_cnt[i] = '0;
    end
    resume_ptr = 0;
    tcount_reg = TCOUNT_W'(MAX_TASKS);
    par_reg = '0;
    err_cnt = 0;

    // Rows run on the reset settings: 16 tasks, none parallel.
    dir_table = '{
      dir_row(1'b1, OP_REQUEST,  1'b0, 4'd0,  16'h0000, 1'b1, 4'd0,  1'b0, 4'd0),
      dir_row(1'b1, OP_REQUEST,  1'b0, 4'd0,  16'h0000, 1'b1, 4'd1,  1'b0, 4'd0),
      dir_row(1'b1, OP_REQUEST,  1'b1, 4'd0,  16'h0001, 1'b1, 4'd2,  1'b1, 4'd0),
      dir_row(1'b1, OP_REQUEST,  1'b1, 4'd1,  16'hFFFF, 1'b0, 4'd0,  1'b1, 4'd1),
      dir_row(1'b1, OP_REQUEST,  1'b1, 4'd15, 16'h8000, 1'b1, 4'd3,  1'b0, 4'd0),
      dir_row(1'b1, OP_SHUTDOWN, 1'b1, 4'd2,  16'hFFFF, 1'b0, 4'd0,  1'b0, 4'd0),
      dir_row(1'b1, OP_SHUTDOWN, 1'b0, 4'd15, 16'h0000, 1'b0, 4'd0,  1'b0, 4'd0),
      dir_row(1'b1, OP_REQUEST,  1'b0, 4'd0,  16'h7FFF, 1'b1, 4'd15, 1'b0, 4'd0),
      dir_row(1'b1, OP_REQUEST,  1'b0, 4'd0,  16'h0000, 1'b1, 4'd0,  1'b0, 4'd0),
      dir_row(1'b1, OP_REQUEST,  1'b1, 4'd3,  16'h0008, 1'b1, 4'd1,  1'b1, 4'd3),
      dir_row(1'b0, OP_REQUEST,  1'b1, 4'd1,  16'h0000, 1'b0, 4'd0,  1'b0, 4'd0),
      dir_row(1'b0, OP_REQUEST,  1'b0, 4'd0,  16'hFFFE, 1'b0, 4'd0,  1'b0, 4'd0),
      dir_row(1'b0, OP_SHUTDOWN, 1'b1, 4'd0,  16'h0000, 1'b0, 4'd0,  1'b0, 4'd0),
      dir_row(1'b0, OP_REQUEST,  1'b1, 4'd15, 16'h8000, 1'b0, 4'd0,  1'b0, 4'd0),
      dir_row(1'b0, OP_REQUEST,  1'b0, 4'd10, 16'hAAAA, 1'b0, 4'd0,  1'b0, 4'd0),
      dir_row(1'b0, OP_REQUEST,  1'b1, 4'd5,  16'h5555, 1'b0, 4'd0,  1'b0, 4'd0)
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    reset_done = 1'b1;

    foreach (dir_table[r]) begin
      send_req(dir_table[r].req);
      got = assign_next(dir_table[r].req);
      expected_assignments.push_back(dir_table[r].known ? dir_table[r].res : got);
    end
    in_valid <= 1'b0;
    wait_drained;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      sat = 1'b0;
      no_gaps = 1'b0;
      n_items = 150;
      pm = MASK_W'($urandom);
      case (ph)
        0: begin
          // A count of zero behaves as a single task.
          tc = '0;
          pm = '0;
          n_items = 120;
        end
        1: begin
          // One parallel task granted over and over until its count saturates.
          tc = TCOUNT_W'(1);
          pm = '1;
          sat = 1'b1;
          no_gaps = 1'b1;
          n_items = 300;
        end
        2: begin
          tc = TCOUNT_W'(MAX_TASKS);
          pm = '1;
        end
        3: tc = '1;
        4: begin
          tc = TCOUNT_W'(MAX_TASKS + 1);
          pm = '0;
          n_items = 120;
        end
        5: tc = TCOUNT_W'(3);
        6: tc = TCOUNT_W'($urandom_range(2, MAX_TASKS - 1));
        default: begin
          tc = TCOUNT_W'(MAX_TASKS);
          pm = '0;
          n_items = 200;
        end
      endcase
      configure(tc, pm);
      if (ph == 3) begin
        hold_off_req = 1'b1;
      end
      for (int k = 0; k < n_items; k++) begin
        rq = make_req(sat);
        send_req(rq);
        expected_assignments.push_back(assign_next(rq));
      end
      in_valid <= 1'b0;
      wait_drained;
    end

    repeat (30) @(posedge clk);
    if (expected_assignments.size() != 0) begin
      $error("%0d expected results never arrived", expected_assignments.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("round_robin_task_assigner test passed");
    end else begin
      $display("round_robin_task_assigner test failed");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned gap;
    out_stall <= 1'b0;
    wait (reset_done);
    forever begin
      if (hold_off_req) begin
        gap = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 6);
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    rrta_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_assignments.size() == 0) begin
        $error("result beat with no expectation waiting");
        err_cnt++;
      end else begin
        want = expected_assignments.pop_front();
        check_field("granted", 8'(want.granted), 8'(granted));
        check_field("granted_task", 8'(want.granted_task), 8'(granted_task));
        check_field("deactivated", 8'(want.deactivated), 8'(deactivated));
        check_field("deactivated_task", 8'(want.deactivated_task), 8'(deactivated_task));
      end
    end
  end

  // Ends the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("round_robin_task_assigner test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rrta_pkg.sv
hw/rtl/rrta_ram.sv
hw/rtl/rrta_cfg.sv
hw/rtl/rrta_engine.sv
hw/rtl/round_robin_task_assigner.sv
verif/round_robin_task_assigner_tb.sv
